FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the route builder RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("route builder assertion failed");
`define SRB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("route builder assertion failed during reset");
`else
`define SRB_ASSERT(lbl, prop)
`define SRB_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/core/srb_pkg.sv
// Shared types and constants of the sweep route builder.
// No dependencies; imported by srb_cell and sweep_route_builder.
package srb_pkg;
    localparam int DEM_W       = 16;
    localparam int CAP_W       = 16;
    localparam int VCNT_W      = 5;
    localparam int NODE_W      = 5;
    localparam int ROUTE_W     = 4;
    localparam int REM_W       = 17;
    localparam int MAX_RESULTS = 48;
    localparam int ROUTE_LIMIT = 16;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_VCOUNT   = 2'd1;
    localparam logic [1:0] CFG_DEPOT_X  = 2'd2;
    localparam logic [1:0] CFG_DEPOT_Y  = 2'd3;

    localparam logic [1:0] HC_NEG_Y = 2'd0;
    localparam logic [1:0] HC_ZERO  = 2'd1;
    localparam logic [1:0] HC_POS_Y = 2'd2;
    localparam logic [1:0] HC_PI    = 2'd3;

    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

    function automatic logic [1:0] half_class(input logic neg_y, input logic zero_y,
                                              input logic neg_x);
        logic [1:0] c;
        if (neg_y) begin
            c = HC_NEG_Y;
        end else if (zero_y) begin
            c = neg_x ? HC_PI : HC_ZERO;
        end else begin
            c = HC_POS_Y;
        end
        return c;
    endfunction
endpackage

FILE: rtl/core/srb_cell.sv
// One entry of the customer chain: loads an arrival or swaps with a neighbor.
// Depends on srb_pkg.
module srb_cell #(
    parameter int CW = 16
) (
    input  logic                      i_clk,
    input  srb_pkg::t_cell_ctl        i_ctl,
    input  logic signed [CW-1:0]      i_ld_x,
    input  logic signed [CW-1:0]      i_ld_y,
    input  logic [srb_pkg::DEM_W-1:0] i_ld_dem,
    input  logic [srb_pkg::NODE_W-1:0] i_ld_num,
    input  logic signed [CW-1:0]      i_prev_x,
    input  logic signed [CW-1:0]      i_prev_y,
    input  logic [srb_pkg::DEM_W-1:0] i_prev_dem,
    input  logic [srb_pkg::NODE_W-1:0] i_prev_num,
    input  logic signed [CW-1:0]      i_next_x,
    input  logic signed [CW-1:0]      i_next_y,
    input  logic [srb_pkg::DEM_W-1:0] i_next_dem,
    input  logic [srb_pkg::NODE_W-1:0] i_next_num,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic [srb_pkg::DEM_W-1:0] o_dem,
    output logic [srb_pkg::NODE_W-1:0] o_num
);
    import srb_pkg::*;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [DEM_W-1:0]     r_dem;
    logic [NODE_W-1:0]    r_num;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_ld_x;
            r_y   <= i_ld_y;
            r_dem <= i_ld_dem;
            r_num <= i_ld_num;
        end else if (i_ctl.take_prev) begin
            r_x   <= i_prev_x;
            r_y   <= i_prev_y;
            r_dem <= i_prev_dem;
            r_num <= i_prev_num;
        end else if (i_ctl.take_next) begin
            r_x   <= i_next_x;
            r_y   <= i_next_y;
            r_dem <= i_next_dem;
            r_num <= i_next_num;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_dem = r_dem;
    assign o_num = r_num;
endmodule

FILE: rtl/core/sweep_route_builder.sv
// Sweep route builder: loading takes customers with no result.
// After the last customer: odd-even sort in the cell chain, route counting
// over the served customers, a check state, then one result per cycle.
// A run with no served customer answers in the cycle after the last transfer.
// Synchronous active-low reset clears counters, state and registers to defaults.
`include "assert_macros.svh"
module sweep_route_builder #(
    parameter int MAX_CUSTOMERS = 16,
    parameter int COORD_WIDTH   = 16,
    localparam int CFG_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_cust_x,
    input  logic signed [COORD_WIDTH-1:0] i_cust_y,
    input  logic [srb_pkg::DEM_W-1:0]     i_demand,
    input  logic                          i_last_customer,
    output logic                          o_valid,
    output logic [srb_pkg::NODE_W-1:0]    o_node,
    output logic [srb_pkg::ROUTE_W-1:0]   o_route_number,
    output logic signed [srb_pkg::REM_W-1:0] o_remaining_load,
    output logic                          o_route_end,
    output logic                          o_infeasible,
    output logic                          o_none_served,
    output logic                          o_overflow,
    output logic                          o_last_result
);
    import srb_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MC    = MAX_CUSTOMERS;
    localparam int CNT_W = $clog2(MC + 1);
    localparam int IDX_W = (MC > 1) ? $clog2(MC) : 1;
    localparam int RT_W  = $clog2(MC + 2);
    localparam int DW    = CW + 1;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SORT  = 4'd1;
    localparam logic [3:0] S_COUNT = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_VISIT = 4'd4;
    localparam logic [3:0] S_OPEN  = 4'd5;
    localparam logic [3:0] S_NEWC  = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;

    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_arr;
    logic [CNT_W-1:0]        r_srv;
    logic                    r_ovf;
    logic [CNT_W-1:0]        r_pass;
    logic [CNT_W-1:0]        r_idx;
    logic signed [REM_W-1:0] r_rem;
    logic [RT_W-1:0]         r_routes;
    logic [ROUTE_W-1:0]      r_route;
    logic [CAP_W-1:0]        r_cap;
    logic [VCNT_W-1:0]       r_vcnt;
    logic signed [CW-1:0]    r_dx;
    logic signed [CW-1:0]    r_dy;

    logic signed [CW-1:0] c_x   [MC];
    logic signed [CW-1:0] c_y   [MC];
    logic [DEM_W-1:0]     c_dem [MC];
    logic [NODE_W-1:0]    c_num [MC];
    t_cell_ctl            c_ctl [MC];
    logic                 swp   [MC];

    logic                    accept;
    logic                    store_it;
    logic                    room;
    logic [NODE_W-1:0]       n_num;
    logic [DEM_W-1:0]        q_dem;
    logic signed [REM_W-1:0] q_s;
    logic signed [REM_W-1:0] cap_s;
    logic                    fits;
    logic                    idx_last;
    logic [VCNT_W-1:0]       vlim;

    assign busy     = (r_state != S_LOAD);
    assign accept   = start && !busy;
    assign room     = (r_arr < CNT_W'(MC));
    assign store_it = accept && room && (i_demand != '0);
    assign n_num    = NODE_W'(r_arr) + NODE_W'(1);
    assign q_dem    = c_dem[r_idx[IDX_W-1:0]];
    assign q_s      = $signed({1'b0, q_dem});
    assign cap_s    = $signed({1'b0, r_cap});
    assign fits     = (q_s <= r_rem);
    assign idx_last = (r_idx == r_srv - CNT_W'(1));
    assign vlim     = (r_vcnt > VCNT_W'(ROUTE_LIMIT)) ? VCNT_W'(ROUTE_LIMIT) : r_vcnt;

    genvar j;
    generate
        for (j = 0; j < MC; j++) begin : g_pair
            if (j < MC - 1) begin : g_cmp
                logic signed [DW-1:0]   ax, ay, bx, by;
                logic signed [2*DW-1:0] p, q;
                logic [1:0]             ca, cb;
                logic                   b_first;
                assign ax = DW'(c_x[j]) - DW'(r_dx);
                assign ay = DW'(c_y[j]) - DW'(r_dy);
                assign bx = DW'(c_x[j+1]) - DW'(r_dx);
                assign by = DW'(c_y[j+1]) - DW'(r_dy);
                assign ca = half_class(ay < 0, ay == 0, ax < 0);
                assign cb = half_class(by < 0, by == 0, bx < 0);
                assign p  = bx * ay;
                assign q  = by * ax;
                always_comb begin
                    if (ca != cb) begin
                        b_first = (cb < ca);
                    end else if ((cb == HC_NEG_Y || cb == HC_POS_Y) && p != q) begin
                        b_first = (p > q);
                    end else begin
                        b_first = (c_num[j+1] < c_num[j]);
                    end
                end
                assign swp[j] = (r_state == S_SORT) && (r_pass[0] == 1'(j % 2)) &&
                                (CNT_W'(j + 1) < r_srv) && b_first;
            end else begin : g_end
                assign swp[j] = 1'b0;
            end
        end

        for (j = 0; j < MC; j++) begin : g_cell
            localparam int PV = (j > 0) ? j - 1 : 0;
            localparam int NX = (j < MC - 1) ? j + 1 : MC - 1;
            assign c_ctl[j].load      = store_it && (r_srv == CNT_W'(j));
            assign c_ctl[j].take_prev = (j > 0) ? swp[PV] : 1'b0;
            assign c_ctl[j].take_next = swp[j];
            srb_cell #(.CW(CW)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (c_ctl[j]),
                .i_ld_x    (i_cust_x),
                .i_ld_y    (i_cust_y),
                .i_ld_dem  (i_demand),
                .i_ld_num  (n_num),
                .i_prev_x  (c_x[PV]),
                .i_prev_y  (c_y[PV]),
                .i_prev_dem(c_dem[PV]),
                .i_prev_num(c_num[PV]),
                .i_next_x  (c_x[NX]),
                .i_next_y  (c_y[NX]),
                .i_next_dem(c_dem[NX]),
                .i_next_num(c_num[NX]),
                .o_x       (c_x[j]),
                .o_y       (c_y[j]),
                .o_dem     (c_dem[j]),
                .o_num     (c_num[j])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_arr    <= '0;
            r_srv    <= '0;
            r_ovf    <= 1'b0;
            r_pass   <= '0;
            r_idx    <= '0;
            r_routes <= '0;
            r_route  <= '0;
            r_rem    <= '0;
            r_cap    <= CAP_W'(1000);
            r_vcnt   <= VCNT_W'(16);
            r_dx     <= '0;
            r_dy     <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY: r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_VCOUNT:   r_vcnt <= i_cfg_data[VCNT_W-1:0];
                    CFG_DEPOT_X:  r_dx   <= i_cfg_data[CW-1:0];
                    CFG_DEPOT_Y:  r_dy   <= i_cfg_data[CW-1:0];
                    default:      r_cap  <= r_cap;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            r_arr <= r_arr + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (store_it) begin
                            r_srv <= r_srv + CNT_W'(1);
                        end
                        if (i_last_customer) begin
                            if (r_srv == '0 && !store_it) begin
                                o_valid          <= 1'b1;
                                o_node           <= '0;
                                o_route_number   <= '0;
                                o_remaining_load <= '0;
                                o_route_end      <= 1'b0;
                                o_infeasible     <= 1'b0;
                                o_none_served    <= 1'b1;
                                o_overflow       <= r_ovf || !room;
                                o_last_result    <= 1'b1;
                                r_arr            <= '0;
                                r_srv            <= '0;
                                r_ovf            <= 1'b0;
                            end else begin
                                r_state <= S_SORT;
                                r_pass  <= '0;
                            end
                        end
                    end
                end
                S_SORT: begin
                    r_pass <= r_pass + CNT_W'(1);
                    if (r_pass == CNT_W'(MC - 1)) begin
                        r_state  <= S_COUNT;
                        r_idx    <= '0;
                        r_rem    <= cap_s;
                        r_routes <= RT_W'(1);
                    end
                end
                S_COUNT: begin
                    if (fits) begin
                        r_rem <= r_rem - q_s;
                    end else begin
                        r_routes <= r_routes + RT_W'(1);
                        r_rem    <= cap_s - q_s;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                    if (idx_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    o_valid       <= 1'b1;
                    o_node        <= '0;
                    o_route_number <= '0;
                    o_route_end   <= 1'b0;
                    o_none_served <= 1'b0;
                    o_overflow    <= r_ovf;
                    if (int'(r_routes) > int'(vlim) ||
                        2 * int'(r_routes) + int'(r_srv) > MAX_RESULTS) begin
                        o_remaining_load <= '0;
                        o_infeasible     <= 1'b1;
                        o_last_result    <= 1'b1;
                        r_state          <= S_LOAD;
                        r_arr            <= '0;
                        r_srv            <= '0;
                        r_ovf            <= 1'b0;
                    end else begin
                        o_remaining_load <= cap_s;
                        o_infeasible     <= 1'b0;
                        o_last_result    <= 1'b0;
                        r_rem            <= cap_s;
                        r_route          <= '0;
                        r_idx            <= '0;
                        r_state          <= S_VISIT;
                    end
                end
                S_VISIT: begin
                    o_valid        <= 1'b1;
                    o_route_number <= r_route;
                    o_infeasible   <= 1'b0;
                    o_none_served  <= 1'b0;
                    o_overflow     <= r_ovf;
                    o_last_result  <= 1'b0;
                    if (fits) begin
                        o_node           <= c_num[r_idx[IDX_W-1:0]];
                        o_remaining_load <= r_rem - q_s;
                        o_route_end      <= 1'b0;
                        r_rem            <= r_rem - q_s;
                        r_idx            <= r_idx + CNT_W'(1);
                        if (idx_last) begin
                            r_state <= S_CLOSE;
                        end
                    end else begin
                        o_node           <= '0;
                        o_remaining_load <= r_rem;
                        o_route_end      <= 1'b1;
                        r_state          <= S_OPEN;
                    end
                end
                S_OPEN: begin
                    o_valid          <= 1'b1;
                    o_node           <= '0;
                    o_route_number   <= r_route + ROUTE_W'(1);
                    o_remaining_load <= cap_s;
                    o_route_end      <= 1'b0;
                    o_infeasible     <= 1'b0;
                    o_none_served    <= 1'b0;
                    o_overflow       <= r_ovf;
                    o_last_result    <= 1'b0;
                    r_route          <= r_route + ROUTE_W'(1);
                    r_state          <= S_NEWC;
                end
                S_NEWC: begin
                    o_valid          <= 1'b1;
                    o_node           <= c_num[r_idx[IDX_W-1:0]];
                    o_route_number   <= r_route;
                    o_remaining_load <= cap_s - q_s;
                    o_route_end      <= 1'b0;
                    o_infeasible     <= 1'b0;
                    o_none_served    <= 1'b0;
                    o_overflow       <= r_ovf;
                    o_last_result    <= 1'b0;
                    r_rem            <= cap_s - q_s;
                    r_idx            <= r_idx + CNT_W'(1);
                    r_state          <= idx_last ? S_CLOSE : S_VISIT;
                end
                S_CLOSE: begin
                    o_valid          <= 1'b1;
                    o_node           <= '0;
                    o_route_number   <= r_route;
                    o_remaining_load <= r_rem;
                    o_route_end      <= 1'b1;
                    o_infeasible     <= 1'b0;
                    o_none_served    <= 1'b0;
                    o_overflow       <= r_ovf;
                    o_last_result    <= 1'b1;
                    r_state          <= S_LOAD;
                    r_arr            <= '0;
                    r_srv            <= '0;
                    r_ovf            <= 1'b0;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    `SRB_ASSERT(a_sort_silent, (r_state == S_SORT) |-> !o_valid)
    `SRB_ASSERT(a_infeasible_alone, o_valid && o_infeasible |-> o_last_result && o_node == '0)
    `SRB_ASSERT(a_served_le_arrived, r_srv <= r_arr)
    `SRB_ASSERT(a_midrun_busy, o_valid && !o_last_result |-> busy)
endmodule
